### design/chd_pkg.sv
// Shared types and constants for the canonical Huffman decoder.
// Depends on nothing; every other design file but chd_checker imports it.
package chd_pkg;

    // Width of the per-length code count field (fixed by the header format).
    localparam int unsigned COUNT_W = 10;

    // Request command codes.
    typedef enum logic [1:0] {
        CMD_RESTART  = 2'd0,
        CMD_LOAD_SYM = 2'd1,
        CMD_LOAD_LEN = 2'd2,
        CMD_CODE_BIT = 2'd3
    } cmd_e;

    // Result status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // One-hot strobes derived from the request being executed.
    typedef struct packed {
        logic restart;
        logic load_sym;
        logic load_len;
        logic code_bit;
    } cmd_ctrl_t;

    // Outcome of one code bit.
    typedef struct packed {
        logic found;
        logic too_long;
    } walk_res_t;

endpackage

### design/chd_len_table.sv
// Register file of code counts per code length, with its load pointer.
// Depends on chd_pkg.
module chd_len_table
    import chd_pkg::*;
#(
    parameter int unsigned MAX_CODE_LEN = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cmd_ctrl_t                       ctrl,
    input  logic [COUNT_W-1:0]              count_value,
    input  logic [$clog2(MAX_CODE_LEN)-1:0] rd_len,
    output logic [COUNT_W-1:0]              rd_count
);

    localparam int unsigned PL_W = $clog2(MAX_CODE_LEN);
    localparam int unsigned LP_W = $clog2(MAX_CODE_LEN + 1);

    logic [LP_W-1:0]    len_ptr_reg;
    logic [LP_W-1:0]    len_ptr_next;
    logic [COUNT_W-1:0] counts_reg [MAX_CODE_LEN];
    logic               room;

    assign room = (len_ptr_reg < LP_W'(MAX_CODE_LEN));

    always_comb
    begin
        len_ptr_next = len_ptr_reg;
        if (ctrl.restart)
        begin
            len_ptr_next = '0;
        end
        else if (ctrl.load_len && room)
        begin
            len_ptr_next = len_ptr_reg + LP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_ptr_reg <= '0;
        end
        else
        begin
            len_ptr_reg <= len_ptr_next;
        end
    end

    // Entries at or above the load pointer read as zero, so a restart
    // needs no clearing of the entries themselves.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_len && room)
        begin
            counts_reg[len_ptr_reg[PL_W-1:0]] <= count_value;
        end
    end

    assign rd_count = (LP_W'(rd_len) < len_ptr_reg) ? counts_reg[rd_len] : '0;

endmodule

### design/chd_code_walker.sv
// Bit-by-bit canonical code walker: partial code, first code and base index.
// Depends on chd_pkg.
module chd_code_walker
    import chd_pkg::*;
#(
    parameter int unsigned MAX_CODE_LEN = 32
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  cmd_ctrl_t                                 ctrl,
    input  logic                                      code_bit,
    input  logic [COUNT_W-1:0]                        count,
    output logic [$clog2(MAX_CODE_LEN)-1:0]           cur_len,
    output logic [$clog2(MAX_CODE_LEN)+COUNT_W-1:0]   idx,
    output walk_res_t                                 res
);

    localparam int unsigned PL_W   = $clog2(MAX_CODE_LEN);
    localparam int unsigned BASE_W = PL_W + COUNT_W;
    // The first code stays below 2^(MAX_CODE_LEN+COUNT_W+1); it is kept
    // modulo 2^64 when that bound exceeds 64 bits.
    localparam int unsigned FC_W   = (MAX_CODE_LEN + COUNT_W + 1 > 64) ?
                                     64 : MAX_CODE_LEN + COUNT_W + 1;

    logic [MAX_CODE_LEN-2:0] partial_code_reg;
    logic [MAX_CODE_LEN-2:0] partial_code_next;
    logic [PL_W-1:0]         plen_reg;
    logic [PL_W-1:0]         plen_next;
    logic [FC_W-1:0]         first_code_reg;
    logic [FC_W-1:0]         first_code_next;
    logic [BASE_W-1:0]       base_reg;
    logic [BASE_W-1:0]       base_next;

    logic [MAX_CODE_LEN-1:0] code;
    logic [FC_W-1:0]         code_ext;
    logic [FC_W-1:0]         diff;
    logic [FC_W-1:0]         first_sum;

    assign code      = {partial_code_reg, code_bit};
    assign code_ext  = FC_W'(code);
    assign diff      = code_ext - first_code_reg;
    assign first_sum = first_code_reg + FC_W'(count);

    assign res.found    = (code_ext >= first_code_reg) && (diff < FC_W'(count));
    assign res.too_long = !res.found && (plen_reg == PL_W'(MAX_CODE_LEN - 1));
    assign idx          = base_reg + BASE_W'(diff[COUNT_W-1:0]);
    assign cur_len      = plen_reg;

    always_comb
    begin
        partial_code_next = partial_code_reg;
        plen_next         = plen_reg;
        first_code_next   = first_code_reg;
        base_next         = base_reg;
        if (ctrl.restart || (ctrl.code_bit && (res.found || res.too_long)))
        begin
            partial_code_next = '0;
            plen_next         = '0;
            first_code_next   = '0;
            base_next         = '0;
        end
        else if (ctrl.code_bit)
        begin
            partial_code_next = code[MAX_CODE_LEN-2:0];
            plen_next         = plen_reg + PL_W'(1);
            first_code_next   = {first_sum[FC_W-2:0], 1'b0};
            base_next         = base_reg + BASE_W'(count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_code_reg <= '0;
            plen_reg         <= '0;
            first_code_reg   <= '0;
            base_reg         <= '0;
        end
        else
        begin
            partial_code_reg <= partial_code_next;
            plen_reg         <= plen_next;
            first_code_reg   <= first_code_next;
            base_reg         <= base_next;
        end
    end

endmodule

### design/chd_sym_store.sv
// Symbol list memory in code order, its load pointer and the registered read.
// Depends on chd_pkg.
module chd_sym_store
    import chd_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS = 512,
    parameter int unsigned SYMBOL_BITS = 9,
    parameter int unsigned IDX_W       = 15
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_ctrl_t              ctrl,
    input  logic [SYMBOL_BITS-1:0] symbol_value,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_idx,
    output logic                   idx_in_range,
    output logic [SYMBOL_BITS-1:0] rd_data
);

    localparam int unsigned AW    = $clog2(MAX_SYMBOLS);
    localparam int unsigned SP_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int unsigned CMP_W = (SP_W > IDX_W) ? SP_W : IDX_W;

    logic [SP_W-1:0]        sym_ptr_reg;
    logic [SP_W-1:0]        sym_ptr_next;
    logic [SYMBOL_BITS-1:0] mem [MAX_SYMBOLS];
    logic [SYMBOL_BITS-1:0] rd_data_reg;
    logic [CMP_W-1:0]       idx_ext;
    logic                   room;
    logic                   wr_en;

    assign room    = (sym_ptr_reg < SP_W'(MAX_SYMBOLS));
    assign wr_en   = ctrl.load_sym && room;
    assign idx_ext = CMP_W'(rd_idx);

    // Being below the load pointer also keeps the index inside the memory.
    assign idx_in_range = (idx_ext < CMP_W'(sym_ptr_reg));

    always_comb
    begin
        sym_ptr_next = sym_ptr_reg;
        if (ctrl.restart)
        begin
            sym_ptr_next = '0;
        end
        else if (wr_en)
        begin
            sym_ptr_next = sym_ptr_reg + SP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_ptr_reg <= '0;
        end
        else
        begin
            sym_ptr_reg <= sym_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[sym_ptr_reg[AW-1:0]] <= symbol_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_ext[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/canonical_huffman_decoder.sv
// Canonical Huffman decoder: top level with request register, result register
// and handshake control. Depends on chd_pkg, chd_len_table, chd_code_walker
// and chd_sym_store.
//
// The block takes one request per unstalled cycle and decodes one code bit per
// request. A restart request clears the code-count table, both load pointers
// and the partial code; the symbol list is then loaded in code order, one
// symbol per request, followed by the code counts for lengths 1, 2 and so on.
// Each code-bit request extends the partial code, and when the code is
// complete the symbol is looked up and returned with status 0. A code that
// reaches MAX_CODE_LEN bits without a match, or whose table index lies beyond
// the loaded symbols, gives status 1 with a zero symbol. Loads past the end
// of either list are ignored. While a request sits in the request register,
// the decode logic performs a single count lookup, one subtract-and-compare
// against the first code and one index add; the symbol memory read is
// registered and forms the result register. A request thus passes the
// request register and then the result register, and a new request can be
// accepted every cycle while no result waits for out_ready. While a result
// waits for out_ready the request register still takes one request. No
// clearing pass follows reset: symbol memory data is only used below its
// load pointer and the count table reads as zero above its own pointer.
module canonical_huffman_decoder
    import chd_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS  = 512,
    parameter int unsigned MAX_CODE_LEN = 32,
    parameter int unsigned SYMBOL_BITS  = 9
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             command,
    input  logic [SYMBOL_BITS-1:0] symbol_value,
    input  logic [COUNT_W-1:0]     count_value,
    input  logic                   code_bit,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SYMBOL_BITS-1:0] decoded_symbol,
    output logic                   status
);

    localparam int unsigned PL_W   = $clog2(MAX_CODE_LEN);
    localparam int unsigned BASE_W = PL_W + COUNT_W;

    // Request register.
    logic                   req_valid_reg;
    logic                   req_valid_next;
    cmd_e                   cmd_reg;
    logic [SYMBOL_BITS-1:0] sym_reg;
    logic [COUNT_W-1:0]     cnt_reg;
    logic                   bit_reg;

    // Result register (the symbol itself sits in the memory read register).
    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic                   res_status_reg;
    logic                   res_status_next;

    logic                   in_fire;
    logic                   advance;
    logic                   exec;
    cmd_ctrl_t              ctrl;
    walk_res_t              walk;
    logic [COUNT_W-1:0]     cur_count;
    logic [PL_W-1:0]        cur_len;
    logic [BASE_W-1:0]      idx;
    logic                   idx_in_range;
    logic                   lookup;
    logic [SYMBOL_BITS-1:0] rd_data;

    // The pipeline moves whenever the result register is empty or drained.
    assign advance  = !res_valid_reg || out_ready;
    assign exec     = req_valid_reg && advance;
    assign in_ready = advance || !req_valid_reg;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        ctrl = '0;
        if (exec)
        begin
            unique case (cmd_reg)
                CMD_RESTART:  ctrl.restart  = 1'b1;
                CMD_LOAD_SYM: ctrl.load_sym = 1'b1;
                CMD_LOAD_LEN: ctrl.load_len = 1'b1;
                CMD_CODE_BIT: ctrl.code_bit = 1'b1;
                default:      ctrl = '0;
            endcase
        end
    end

    // A matched code reads the symbol memory; its data lands with the result.
    assign lookup = ctrl.code_bit && walk.found;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (in_fire)
        begin
            req_valid_next = 1'b1;
        end
        else if (exec)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        if (advance)
        begin
            res_valid_next  = ctrl.code_bit && (walk.found || walk.too_long);
            res_status_next = (walk.too_long || !idx_in_range) ? STATUS_ERR : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= STATUS_OK;
        end
        else
        begin
            req_valid_reg  <= req_valid_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= cmd_e'(command);
            sym_reg <= symbol_value;
            cnt_reg <= count_value;
            bit_reg <= code_bit;
        end
    end

    chd_len_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_len_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .count_value (cnt_reg),
        .rd_len      (cur_len),
        .rd_count    (cur_count)
    );

    chd_code_walker #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_code_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .code_bit (bit_reg),
        .count    (cur_count),
        .cur_len  (cur_len),
        .idx      (idx),
        .res      (walk)
    );

    chd_sym_store #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .SYMBOL_BITS (SYMBOL_BITS),
        .IDX_W       (BASE_W)
    ) u_sym_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .symbol_value (sym_reg),
        .rd_en        (lookup),
        .rd_idx       (idx),
        .idx_in_range (idx_in_range),
        .rd_data      (rd_data)
    );

    assign out_valid      = res_valid_reg;
    assign status         = res_status_reg;
    assign decoded_symbol = (res_status_reg == STATUS_ERR) ? '0 : rd_data;

endmodule

### design/chd_checker.sv
// Port-level assertions for the canonical Huffman decoder, bound to the top.
// Depends on canonical_huffman_decoder.
module chd_checker
#(
    parameter int unsigned SYMBOL_BITS = 9
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SYMBOL_BITS-1:0] decoded_symbol,
    input logic                   status
);

    // A stalled result keeps its value.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(decoded_symbol) && $stable(status))
    else $error("result changed while stalled");

    // An error result always carries a zero symbol.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> decoded_symbol == '0)
    else $error("error result with non-zero symbol");

    // With no result pending the block always takes a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("request refused with empty result register");

    // No result is present when reset is seen released.
    a_no_result_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
    else $error("result present straight after reset");

endmodule

bind canonical_huffman_decoder chd_checker #(
    .SYMBOL_BITS (SYMBOL_BITS)
) u_chd_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .decoded_symbol (decoded_symbol),
    .status         (status)
);

### dv/tb_canonical_huffman_decoder.sv
// Self-checking testbench for canonical_huffman_decoder: a directed table of requests,
// then random header loads and code streams scored against a built-in decoder model.
// Depends on chd_pkg and the design sources of the decoder.
module tb_canonical_huffman_decoder;
    import chd_pkg::*;

    localparam int unsigned SYM_DEPTH   = 512;
    localparam int unsigned CODE_LIMIT  = 32;
    localparam int unsigned SYM_W       = 9;
    // Cycles without any handshake before the run is declared hung. The longest
    // legitimate quiet stretch is the deliberate receiver hold-off below.
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned PHASE_ITEMS = 300;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef struct packed {
        cmd_e               command;
        logic [SYM_W-1:0]   symbol;
        logic [COUNT_W-1:0] count;
        logic               cbit;
    } request_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             status;
    } decode_t;

    // One row of the directed part. Where typed is set, the expected result is
    // the one written in the row; otherwise the model decides.
    typedef struct packed {
        cmd_e               command;
        logic [SYM_W-1:0]   symbol;
        logic [COUNT_W-1:0] count;
        logic               cbit;
        logic               typed;
        logic [SYM_W-1:0]   exp_symbol;
        logic               exp_status;
    } table_row_t;

    logic                   clk;
    logic                   rst_n          = 1'b0;
    logic                   in_valid       = 1'b0;
    logic                   in_ready;
    logic [1:0]             command        = '0;
    logic [SYM_W-1:0]       symbol_value   = '0;
    logic [COUNT_W-1:0]     count_value    = '0;
    logic                   code_bit       = 1'b0;
    logic                   out_valid;
    logic                   out_ready      = 1'b0;
    logic [SYM_W-1:0]       decoded_symbol;
    logic                   status;

    canonical_huffman_decoder uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .symbol_value   (symbol_value),
        .count_value    (count_value),
        .code_bit       (code_bit),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .decoded_symbol (decoded_symbol),
        .status         (status)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Decoder model. Its state mirrors the block: the ordered symbol list,
    // the per-length code counts, both load pointers and the canonical walk
    // (partial code, its length, the first code of that length and the
    // table index where that length starts). Widths follow the block, with
    // the walk held in 64 bits so that inconsistent counts wrap the same way.
    // ------------------------------------------------------------------
    logic [SYM_W-1:0]   sym_table  [SYM_DEPTH];
    logic [COUNT_W-1:0] len_counts [CODE_LIMIT] = '{default: '0};
    int unsigned        sym_fill   = 0;
    int unsigned        len_fill   = 0;
    longint unsigned    walk_code  = 0;
    longint unsigned    walk_first = 0;
    int unsigned        walk_len   = 0;
    int unsigned        walk_base  = 0;

    // Results still owed by the block, oldest first.
    decode_t            pending_decodes [$];

    int unsigned        errors        = 0;
    int unsigned        items_sent    = 0;
    int unsigned        tx_idle_pct   = 0;
    int unsigned        rx_stall_pct  = 0;
    int unsigned        hold_requests = 0;

    function automatic void clear_walk();
        walk_code  = 0;
        walk_first = 0;
        walk_len   = 0;
        walk_base  = 0;
    endfunction

    // Applies one accepted request to the model and says whether it yields a
    // result, and which.
    task automatic huffman_predict(input request_t r, output bit produced, output decode_t res);
        longint unsigned code;
        longint unsigned idx;
        int unsigned     cnt;
        produced = 1'b0;
        res      = '0;
        case (r.command)
            CMD_RESTART:
            begin
                // The symbol list keeps its contents; only the pointers move.
                len_counts = '{default: '0};
                sym_fill   = 0;
                len_fill   = 0;
                clear_walk();
            end
            CMD_LOAD_SYM:
            begin
                if (sym_fill < SYM_DEPTH)
                begin
                    sym_table[sym_fill] = r.symbol;
                    sym_fill++;
                end
            end
            CMD_LOAD_LEN:
            begin
                if (len_fill < CODE_LIMIT)
                begin
                    len_counts[len_fill] = r.count;
                    len_fill++;
                end
            end
            CMD_CODE_BIT:
            begin
                code = (walk_code << 1) | r.cbit;
                cnt  = (walk_len < CODE_LIMIT) ? len_counts[walk_len] : 0;
                if (code >= walk_first && code - walk_first < cnt)
                begin
                    // The code is complete; its offset within this length
                    // picks the symbol, provided that entry was loaded.
                    idx      = walk_base + (code - walk_first);
                    produced = 1'b1;
                    if (idx < sym_fill && idx < SYM_DEPTH)
                        res = '{sym_table[idx], STATUS_OK};
                    else
                        res = '{'0, STATUS_ERR};
                    clear_walk();
                end
                else if (walk_len + 1 >= CODE_LIMIT)
                begin
                    // Longest allowed code reached without a match.
                    produced = 1'b1;
                    res      = '{'0, STATUS_ERR};
                    clear_walk();
                end
                else
                begin
                    walk_base  += cnt;
                    walk_first  = (walk_first + cnt) << 1;
                    walk_code   = code;
                    walk_len++;
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request side. A request is offered at a rising edge and held until
    // in_ready is seen high at a later edge; the model is advanced at that
    // point. Between requests the sender may idle at random.
    // ------------------------------------------------------------------
    task automatic send(input request_t r, input bit typed = 1'b0,
                        input decode_t typed_res = '0);
        bit      produced;
        decode_t res;
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= r.command;
        symbol_value <= r.symbol;
        count_value  <= r.count;
        code_bit     <= r.cbit;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        huffman_predict(r, produced, res);
        if (typed)
            pending_decodes = {pending_decodes, typed_res};
        else if (produced)
            pending_decodes = {pending_decodes, res};
        items_sent++;
    endtask

    // Random payload for every field, so that the unused fields of a request
    // still toggle; the caller overrides what matters.
    function automatic request_t random_request(input cmd_e c);
        request_t r;
        r.command = c;
        r.symbol  = SYM_W'($urandom_range(511, 0));
        r.count   = COUNT_W'($urandom_range(1023, 0));
        r.cbit    = 1'($urandom_range(1, 0));
        return r;
    endfunction

    // Stops offering requests and waits for every owed result, then lets the
    // clock run on so that a code still being walked has settled.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One stretch of stimulus. Most stretches are a complete header for a
    // valid canonical code followed by a stream of whole codes; the rest are
    // an empty table fed raw bits (which exercises the too-long error), a
    // header loaded without a restart, or plain noise.
    task automatic run_sequence(input bit big_table);
        logic [COUNT_W-1:0] counts [CODE_LIMIT];
        int unsigned        kind;
        int unsigned        maxlen;
        int unsigned        total;
        int unsigned        nsym;
        int unsigned        slots;
        int unsigned        remaining;
        int unsigned        c;
        int unsigned        idx;
        int unsigned        base;
        int unsigned        len;
        int unsigned        pick;
        bit                 deep;
        longint unsigned    code;
        request_t           r;
        kind   = $urandom_range(9, 0);
        counts = '{default: '0};
        if (!big_table && kind == 0)
        begin
            // Noise: mostly code bits, with stray restarts and loads.
            repeat ($urandom_range(40, 5))
            begin
                pick = $urandom_range(9, 0);
                r = random_request(pick < 7 ? CMD_CODE_BIT : cmd_e'(pick - 7));
                send(r);
            end
        end
        else if (!big_table && kind == 1)
        begin
            // No counts at all: every 32nd bit ends in the too-long error.
            send(random_request(CMD_RESTART));
            repeat (70)
                send(random_request(CMD_CODE_BIT));
        end
        else
        begin
            // A header loaded on top of an earlier one, without a restart,
            // is the broken case; the model sorts out what it decodes to.
            if (big_table || kind != 2)
                send(random_request(CMD_RESTART));
            if (big_table)
            begin
                // Nine-bit codes take the first 510 entries; the two ten-bit codes beyond
                // the last storable symbol fall outside the table.
                counts[8] = COUNT_W'(510);
                counts[9] = COUNT_W'(4);
                maxlen    = 10;
                total     = 514;
                nsym      = 514;
            end
            else
            begin
                deep      = ($urandom_range(5, 0) == 0);
                maxlen    = deep ? $urandom_range(31, 20) : $urandom_range(10, 1);
                remaining = $urandom_range(24, 1);
                slots     = 2;
                total     = 0;
                for (len = 1; len <= maxlen; len++)
                begin
                    // Kraft bookkeeping: slots is the number of unused codes
                    // of this length, doubled at each step down.
                    if (deep && len + 2 < maxlen)
                        c = 0;
                    else if (len == maxlen)
                        c = (remaining < slots) ? remaining : slots;
                    else
                        c = $urandom_range((remaining < slots) ? remaining : slots, 0);
                    counts[len-1] = COUNT_W'(c);
                    total        += c;
                    remaining    -= c;
                    slots         = (slots - c) * 2;
                    if (slots > 65536)
                        slots = 65536;
                end
                nsym = total;
                case ($urandom_range(5, 0))
                    0:       if (nsym > 0) nsym--;
                    1:       nsym += $urandom_range(3, 1);
                    default: ;
                endcase
            end
            repeat (nsym)
                send(random_request(CMD_LOAD_SYM));
            for (len = 0; len < maxlen; len++)
            begin
                r       = random_request(CMD_LOAD_LEN);
                r.count = counts[len];
                send(r);
            end
            // Occasional extra counts for longer lengths, at times past the
            // end of the count table.
            if ($urandom_range(7, 0) == 0)
                repeat ($urandom_range(4, 1))
                    send(random_request(CMD_LOAD_LEN));
            if (total == 0)
            begin
                repeat (20)
                    send(random_request(CMD_CODE_BIT));
            end
            else
            begin
                repeat ($urandom_range(20, 4))
                begin
                    // Canonical code of a random table index: walk the
                    // lengths until the index falls inside one.
                    idx  = $urandom_range(total - 1, 0);
                    code = 0;
                    base = 0;
                    for (len = 1; len <= maxlen; len++)
                    begin
                        if (idx < base + counts[len-1])
                            break;
                        base += counts[len-1];
                        code  = (code + counts[len-1]) << 1;
                    end
                    code = code + (idx - base);
                    for (int b = len - 1; b >= 0; b--)
                    begin
                        r      = random_request(CMD_CODE_BIT);
                        r.cbit = code[b];
                        send(r);
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: out_ready is rolled afresh each cycle from the stall
    // percentage of the current phase, except during a requested hold-off,
    // when it stays low until the hold-off count in hold_left runs out.
    // ------------------------------------------------------------------
    int unsigned hold_served = 0;
    int unsigned hold_left   = 0;

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left  = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    // Every accepted result is compared, field by field, with the oldest
    // owed one.
    always @(posedge clk)
    begin
        decode_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_decodes.size() == 0)
            begin
                errors++;
                $display("%0t: result with none owed: expected nothing, actual symbol %h status %0d",
                         $time, decoded_symbol, status);
            end
            else
            begin
                want = pending_decodes.pop_front();
                if (decoded_symbol !== want.symbol)
                begin
                    errors++;
                    $display("%0t: decoded_symbol expected %h actual %h",
                             $time, want.symbol, decoded_symbol);
                end
                if (status !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                end
            end
        end
    end

    // Watchdog: any handshake on either side counts as progress.
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed part. A four-symbol code (lengths 1, 2, 3 and 3: codes 0,
    // 10, 110 and 111) is loaded a little at a time, so that the first
    // symbol is decoded before the header is complete. Then a restart and a
    // single count of 1023 make every code index land beyond the empty
    // symbol list. Decodes are typed in; the loads only move the model.
    // ------------------------------------------------------------------
    table_row_t directed_rows [21] = '{
        '{CMD_RESTART,  9'h000, 10'h000, 1'b0, 1'b0, 9'h000, STATUS_OK},
        '{CMD_LOAD_SYM, 9'h1FF, 10'h000, 1'b0, 1'b0, 9'h000, STATUS_OK},
        '{CMD_LOAD_SYM, 9'h000, 10'h3FF, 1'b1, 1'b0, 9'h000, STATUS_OK},
        '{CMD_LOAD_SYM, 9'h155, 10'h000, 1'b0, 1'b0, 9'h000, STATUS_OK},
        '{CMD_LOAD_SYM, 9'h0AA, 10'h000, 1'b0, 1'b0, 9'h000, STATUS_OK},
        '{CMD_LOAD_LEN, 9'h000, 10'h001, 1'b0, 1'b0, 9'h000, STATUS_OK},
        '{CMD_CODE_BIT, 9'h000, 10'h000, 1'b0, 1'b1, 9'h1FF, STATUS_OK},
        '{CMD_LOAD_LEN, 9'h000, 10'h001, 1'b0, 1'b0, 9'h000, STATUS_OK},
        '{CMD_LOAD_LEN, 9'h1FF, 10'h002, 1'b1, 1'b0, 9'h000, STATUS_OK},
        '{CMD_CODE_BIT, 9'h000, 10'h000, 1'b1, 1'b0, 9'h000, STATUS_OK},
        '{CMD_CODE_BIT, 9'h000, 10'h000, 1'b0, 1'b1, 9'h000, STATUS_OK},
        '{CMD_CODE_BIT, 9'h000, 10'h000, 1'b1, 1'b0, 9'h000, STATUS_OK},
        '{CMD_CODE_BIT, 9'h000, 10'h000, 1'b1, 1'b0, 9'h000, STATUS_OK},
        '{CMD_CODE_BIT, 9'h000, 10'h000, 1'b0, 1'b1, 9'h155, STATUS_OK},
        '{CMD_CODE_BIT, 9'h000, 10'h000, 1'b1, 1'b0, 9'h000, STATUS_OK},
        '{CMD_CODE_BIT, 9'h000, 10'h000, 1'b1, 1'b0, 9'h000, STATUS_OK},
        '{CMD_CODE_BIT, 9'h000, 10'h000, 1'b1, 1'b1, 9'h0AA, STATUS_OK},
        '{CMD_RESTART,  9'h000, 10'h000, 1'b0, 1'b0, 9'h000, STATUS_OK},
        '{CMD_LOAD_LEN, 9'h000, 10'h3FF, 1'b0, 1'b0, 9'h000, STATUS_OK},
        '{CMD_CODE_BIT, 9'h000, 10'h000, 1'b1, 1'b1, 9'h000, STATUS_ERR},
        '{CMD_CODE_BIT, 9'h000, 10'h000, 1'b0, 1'b1, 9'h000, STATUS_ERR}
    };

    initial
    begin
        request_t r;
        decode_t  res;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            r   = '{directed_rows[i].command, directed_rows[i].symbol,
                    directed_rows[i].count, directed_rows[i].cbit};
            res = '{directed_rows[i].exp_symbol, directed_rows[i].exp_status};
            send(r, directed_rows[i].typed, res);
        end
        drain();

        // Four phases of random stimulus, each ended by a full drain:
        // free flow with one long receiver hold-off that backs the block up,
        // a mostly idle sender (carrying the one full-size table), a mostly
        // stalled receiver, and both sides idling now and then.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    hold_requests++;
                end
                1:
                begin
                    tx_idle_pct  = 85;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 85;
                end
                default:
                begin
                    tx_idle_pct  = 35;
                    rx_stall_pct = 35;
                end
            endcase
            if (phase == 1)
                run_sequence(1'b1);
            while (items_sent < PHASE_ITEMS * (phase + 1))
                run_sequence(1'b0);
            drain();
        end

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
